>>> hw/rtl/wfsa_pkg.sv
// Shared types and constants for the weighted fair share allocator.
// No dependencies; every other file in hw/rtl except wfsa_ram uses this package.
package wfsa_pkg;

    // Fixed field widths of the item and result channels.
    localparam int WEIGHT_W    = 14;
    localparam int FIELD_AMT_W = 48;
    localparam int OUT_IDX_W   = 4;

    // One datapath operation per cycle, issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SORT_INIT,
        OP_RD_ORD_I,
        OP_RD_ORD_JM1,
        OP_LAT_KEY_IDX,
        OP_LAT_KEY_DAT,
        OP_LAT_PREV_IDX,
        OP_CMP_SORT,
        OP_SHIFT,
        OP_PLACE,
        OP_WALK_INIT,
        OP_LAT_B_IDX,
        OP_CMP_WALK,
        OP_TAKE,
        OP_DIV,
        OP_FILL_WR,
        OP_OUT_INIT,
        OP_RD_SHARE,
        OP_OUT_LAT,
        OP_NEXT_OUT,
        OP_CLEAR
    } dp_op_t;

    // Operation of the multiply/divide unit.
    typedef enum logic {
        MDU_CMP,
        MDU_DIV
    } mdu_op_t;

    // Status flags returned from the datapath to the controller.
    typedef struct packed {
        logic i_at_n;
        logic j_zero;
        logic last_out;
        logic mdu_done;
        logic mdu_ge;
    } dp_status_t;

endpackage

>>> hw/rtl/wfsa_if.sv
// Valid/ready channel interfaces for bucket items and share results.
// Depends on wfsa_pkg for the field widths.
interface wfsa_in_if;
    import wfsa_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [WEIGHT_W-1:0]    weight;
    logic [FIELD_AMT_W-1:0] demand;
    logic [FIELD_AMT_W-1:0] cap_amount;
    logic                   cap_valid;
    logic [FIELD_AMT_W-1:0] capacity;
    logic                   last_bucket;

    modport source (
        output valid, weight, demand, cap_amount, cap_valid, capacity, last_bucket,
        input  ready
    );
    modport sink (
        input  valid, weight, demand, cap_amount, cap_valid, capacity, last_bucket,
        output ready
    );
endinterface

interface wfsa_out_if;
    import wfsa_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OUT_IDX_W-1:0]   bucket_index;
    logic [FIELD_AMT_W-1:0] share;
    logic                   dropped_flag;
    logic                   last_share;

    modport source (
        output valid, bucket_index, share, dropped_flag, last_share,
        input  ready
    );
    modport sink (
        input  valid, bucket_index, share, dropped_flag, last_share,
        output ready
    );
endinterface

>>> hw/rtl/wfsa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module wfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/wfsa_mdu.sv
// Multi-cycle arithmetic unit: exact cross-product compare and long division.
// Depends on wfsa_pkg for the operation code.
module wfsa_mdu #(
    parameter int AW   = 48,
    parameter int SUMW = 18
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  wfsa_pkg::mdu_op_t       op,
    input  logic [AW-1:0]           a1,
    input  logic [SUMW-1:0]         b1,
    input  logic [AW-1:0]           a2,
    input  logic [SUMW-1:0]         b2,
    input  logic [SUMW-1:0]         divisor,
    output logic                    done,
    output logic                    ge,
    output logic [AW-1:0]           quot
);
    import wfsa_pkg::*;

    localparam int NCH   = (AW + 31) / 32;
    localparam int STEPS = 2 * NCH;
    localparam int APW   = 64 + SUMW;
    localparam int PRW   = 32 + SUMW;
    localparam int DW    = AW + SUMW;
    localparam int CTW   = $clog2(DW + 1);

    typedef enum logic [2:0] {
        M_IDLE,
        M_MUL,
        M_CMP,
        M_DLOAD,
        M_DIV
    } mstate_t;

    mstate_t         state_reg, state_next;
    logic [CTW-1:0]  cnt_reg, cnt_next;
    logic            pv_reg, pv_next;
    logic            done_reg, done_next;

    mdu_op_t         op_reg;
    logic [63:0]     a1_reg, a2_reg;
    logic [SUMW-1:0] b1_reg, b2_reg, dvs_reg;
    logic [PRW-1:0]  part_reg;
    logic            tsel_reg;
    logic            tkk_reg;
    logic [APW-1:0]  acc1_reg, acc2_reg;
    logic [DW-1:0]   num_reg;
    logic [SUMW-1:0] rem_reg;
    logic [AW-1:0]   q_reg;
    logic            ge_reg;

    logic            sel2;
    logic            kk;
    logic [31:0]     chunk;
    logic [SUMW-1:0] bsel;
    logic [SUMW:0]   trial;
    logic            qbit;
    logic [APW-1:0]  part_sh;

    // Operand chunk for the current partial product.
    always_comb
    begin
        sel2    = (cnt_reg >= CTW'(NCH));
        kk      = sel2 ? 1'((cnt_reg - CTW'(NCH))) : cnt_reg[0];
        chunk   = sel2 ? a2_reg[kk*32 +: 32] : a1_reg[kk*32 +: 32];
        bsel    = sel2 ? b2_reg : b1_reg;
        part_sh = APW'(part_reg) << (tkk_reg ? 32 : 0);
        trial   = {rem_reg, num_reg[DW-1]};
        qbit    = (trial >= {1'b0, dvs_reg});
    end

    // Sequencing of the unit.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pv_next    = 1'b0;
        done_next  = 1'b0;
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    state_next = M_MUL;
                    cnt_next   = '0;
                end
            end
            M_MUL:
            begin
                if (cnt_reg == CTW'(STEPS))
                begin
                    state_next = (op_reg == MDU_DIV) ? M_DLOAD : M_CMP;
                    cnt_next   = '0;
                end
                else
                begin
                    pv_next  = 1'b1;
                    cnt_next = cnt_reg + CTW'(1);
                end
            end
            M_CMP:
            begin
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            M_DLOAD:
            begin
                state_next = M_DIV;
                cnt_next   = '0;
            end
            M_DIV:
            begin
                cnt_next = cnt_reg + CTW'(1);
                if (cnt_reg == CTW'(DW - 1))
                begin
                    done_next  = 1'b1;
                    state_next = M_IDLE;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            pv_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pv_reg    <= pv_next;
            done_reg  <= done_next;
        end
    end

    // Operand, product, accumulator and divider registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == M_IDLE && start)
        begin
            op_reg   <= op;
            a1_reg   <= 64'(a1);
            a2_reg   <= 64'(a2);
            b1_reg   <= b1;
            b2_reg   <= b2;
            dvs_reg  <= divisor;
            acc1_reg <= '0;
            acc2_reg <= '0;
        end
        if (state_reg == M_MUL)
        begin
            part_reg <= PRW'(chunk) * PRW'(bsel);
            tsel_reg <= sel2;
            tkk_reg  <= kk;
            if (pv_reg)
            begin
                if (tsel_reg)
                begin
                    acc2_reg <= acc2_reg + part_sh;
                end
                else
                begin
                    acc1_reg <= acc1_reg + part_sh;
                end
            end
        end
        if (state_reg == M_CMP)
        begin
            ge_reg <= (acc1_reg >= acc2_reg);
        end
        if (state_reg == M_DLOAD)
        begin
            num_reg <= acc1_reg[DW-1:0];
            rem_reg <= '0;
        end
        if (state_reg == M_DIV)
        begin
            rem_reg <= qbit ? SUMW'(trial - {1'b0, dvs_reg}) : SUMW'(trial);
            q_reg   <= {q_reg[AW-2:0], qbit};
            num_reg <= num_reg << 1;
        end
    end

    assign done = done_reg;
    assign ge   = ge_reg;
    assign quot = q_reg;

endmodule

>>> hw/rtl/wfsa_dp.sv
// Datapath: bucket stores, sort and allocation registers, output register.
// Depends on wfsa_pkg, wfsa_ram and wfsa_mdu.
module wfsa_dp #(
    parameter int MAX_BUCKETS  = 16,
    parameter int AMOUNT_WIDTH = 48
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wfsa_pkg::dp_op_t                     op,
    input  logic [wfsa_pkg::WEIGHT_W-1:0]        weight,
    input  logic [wfsa_pkg::FIELD_AMT_W-1:0]     demand,
    input  logic [wfsa_pkg::FIELD_AMT_W-1:0]     cap_amount,
    input  logic                                 cap_valid,
    input  logic [wfsa_pkg::FIELD_AMT_W-1:0]     capacity,
    output wfsa_pkg::dp_status_t                 status,
    output logic [wfsa_pkg::OUT_IDX_W-1:0]       bucket_index,
    output logic [wfsa_pkg::FIELD_AMT_W-1:0]     share,
    output logic                                 dropped_flag,
    output logic                                 last_share
);
    import wfsa_pkg::*;

    localparam int AW   = AMOUNT_WIDTH;
    localparam int IW   = $clog2(MAX_BUCKETS);
    localparam int CW   = $clog2(MAX_BUCKETS + 1);
    localparam int SUMW = WEIGHT_W + $clog2(MAX_BUCKETS);

    // Round bookkeeping, reset.
    logic [CW-1:0]   cnt_reg;
    logic            ovf_reg;
    logic [SUMW-1:0] wsum_reg;

    // Working registers.
    logic [CW-1:0]       i_reg, j_reg, k_reg;
    logic [AW-1:0]       rem_c_reg;
    logic [SUMW-1:0]     rem_w_reg;
    logic [IW-1:0]       key_idx_reg, prev_idx_reg, b_reg;
    logic [WEIGHT_W-1:0] key_w_reg, cur_w_reg;
    logic [AW-1:0]       key_d_reg, cur_d_reg;
    logic [OUT_IDX_W-1:0]   out_idx_reg;
    logic [FIELD_AMT_W-1:0] out_share_reg;
    logic                   out_drop_reg, out_last_reg;

    // Store ports.
    logic                w_we, cd_we, ord_we, sh_we;
    logic [IW-1:0]       w_waddr, ord_waddr, sh_waddr, ord_raddr;
    logic [WEIGHT_W-1:0] w_wdata, w_rdata;
    logic [AW-1:0]       cd_wdata, cd_rdata, sh_wdata, sh_rdata;
    logic [IW-1:0]       ord_wdata, ord_rdata;

    // Arithmetic unit ports.
    logic            mdu_start, mdu_done, mdu_ge;
    mdu_op_t         mdu_op;
    logic [AW-1:0]   mdu_a1, mdu_a2, mdu_q;
    logic [SUMW-1:0] mdu_b1, mdu_b2, mdu_dvs;

    logic [WEIGHT_W-1:0] w_fix;
    logic [AW-1:0]       dem_m, cap_m, cd_in;
    logic                room;
    logic [CW-1:0]       jm1;

    // Incoming item conditioning.
    always_comb
    begin
        w_fix = (weight == '0) ? WEIGHT_W'(1) : weight;
        dem_m = AW'(demand);
        cap_m = AW'(cap_amount);
        cd_in = (cap_valid && cap_m < dem_m) ? cap_m : dem_m;
        room  = (cnt_reg < CW'(MAX_BUCKETS));
        jm1   = j_reg - CW'(1);
    end

    // Store write and read addressing.
    always_comb
    begin
        w_we      = (op == OP_LOAD) && room;
        cd_we     = w_we;
        w_waddr   = cnt_reg[IW-1:0];
        w_wdata   = w_fix;
        cd_wdata  = cd_in;
        ord_we    = 1'b0;
        ord_waddr = j_reg[IW-1:0];
        ord_wdata = key_idx_reg;
        sh_we     = 1'b0;
        sh_waddr  = b_reg;
        sh_wdata  = cur_d_reg;
        case (op)
            OP_LOAD:
            begin
                ord_we    = room;
                ord_waddr = cnt_reg[IW-1:0];
                ord_wdata = cnt_reg[IW-1:0];
            end
            OP_SHIFT:
            begin
                ord_we    = 1'b1;
                ord_wdata = prev_idx_reg;
            end
            OP_PLACE:
            begin
                ord_we = 1'b1;
            end
            OP_TAKE:
            begin
                sh_we = 1'b1;
            end
            OP_FILL_WR:
            begin
                sh_we    = 1'b1;
                sh_wdata = mdu_q;
            end
            default:
            begin
                ord_we = 1'b0;
            end
        endcase
        ord_raddr = (op == OP_RD_ORD_JM1) ? jm1[IW-1:0] : i_reg[IW-1:0];
    end

    // Arithmetic unit requests.
    always_comb
    begin
        mdu_start = 1'b0;
        mdu_op    = MDU_CMP;
        mdu_a1    = key_d_reg;
        mdu_b1    = SUMW'(w_rdata);
        mdu_a2    = cd_rdata;
        mdu_b2    = SUMW'(key_w_reg);
        mdu_dvs   = (rem_w_reg == '0) ? SUMW'(1) : rem_w_reg;
        case (op)
            OP_CMP_SORT:
            begin
                mdu_start = 1'b1;
            end
            OP_CMP_WALK:
            begin
                mdu_start = 1'b1;
                mdu_a1    = cd_rdata;
                mdu_b1    = rem_w_reg;
                mdu_a2    = rem_c_reg;
                mdu_b2    = SUMW'(w_rdata);
            end
            OP_DIV:
            begin
                mdu_start = 1'b1;
                mdu_op    = MDU_DIV;
                mdu_a1    = rem_c_reg;
                mdu_a2    = '0;
                mdu_b2    = '0;
            end
            default:
            begin
                mdu_start = 1'b0;
            end
        endcase
    end

    // Round bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            wsum_reg <= '0;
        end
        else if (op == OP_LOAD)
        begin
            if (room)
            begin
                cnt_reg  <= cnt_reg + CW'(1);
                wsum_reg <= wsum_reg + SUMW'(w_fix);
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
        else if (op == OP_CLEAR)
        begin
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            wsum_reg <= '0;
        end
    end

    // Working registers of sort, allocation and output.
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                rem_c_reg <= AW'(capacity);
            end
            OP_SORT_INIT:
            begin
                i_reg <= CW'(1);
            end
            OP_LAT_KEY_IDX:
            begin
                key_idx_reg <= ord_rdata;
            end
            OP_LAT_KEY_DAT:
            begin
                key_w_reg <= w_rdata;
                key_d_reg <= cd_rdata;
                j_reg     <= i_reg;
            end
            OP_LAT_PREV_IDX:
            begin
                prev_idx_reg <= ord_rdata;
            end
            OP_SHIFT:
            begin
                j_reg <= jm1;
            end
            OP_PLACE:
            begin
                i_reg <= i_reg + CW'(1);
            end
            OP_WALK_INIT:
            begin
                i_reg     <= '0;
                rem_w_reg <= wsum_reg;
            end
            OP_LAT_B_IDX:
            begin
                b_reg <= ord_rdata;
            end
            OP_CMP_WALK:
            begin
                cur_d_reg <= cd_rdata;
                cur_w_reg <= w_rdata;
            end
            OP_TAKE:
            begin
                rem_c_reg <= rem_c_reg - cur_d_reg;
                rem_w_reg <= rem_w_reg - SUMW'(cur_w_reg);
                i_reg     <= i_reg + CW'(1);
            end
            OP_FILL_WR:
            begin
                i_reg <= i_reg + CW'(1);
            end
            OP_OUT_INIT:
            begin
                k_reg <= '0;
            end
            OP_OUT_LAT:
            begin
                out_idx_reg   <= OUT_IDX_W'(k_reg);
                out_share_reg <= FIELD_AMT_W'(sh_rdata);
                out_drop_reg  <= ovf_reg;
                out_last_reg  <= (k_reg + CW'(1) == cnt_reg);
            end
            OP_NEXT_OUT:
            begin
                k_reg <= k_reg + CW'(1);
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    // Bucket stores.
    wfsa_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_BUCKETS)) u_w_ram (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(ord_rdata), .rdata(w_rdata)
    );
    wfsa_ram #(.WIDTH(AW), .DEPTH(MAX_BUCKETS)) u_cd_ram (
        .clk(clk), .we(cd_we), .waddr(w_waddr), .wdata(cd_wdata),
        .raddr(ord_rdata), .rdata(cd_rdata)
    );
    wfsa_ram #(.WIDTH(IW), .DEPTH(MAX_BUCKETS)) u_ord_ram (
        .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
        .raddr(ord_raddr), .rdata(ord_rdata)
    );
    wfsa_ram #(.WIDTH(AW), .DEPTH(MAX_BUCKETS)) u_sh_ram (
        .clk(clk), .we(sh_we), .waddr(sh_waddr), .wdata(sh_wdata),
        .raddr(k_reg[IW-1:0]), .rdata(sh_rdata)
    );

    // Compare and divide unit.
    wfsa_mdu #(.AW(AW), .SUMW(SUMW)) u_mdu (
        .clk(clk), .rst_n(rst_n), .start(mdu_start), .op(mdu_op),
        .a1(mdu_a1), .b1(mdu_b1), .a2(mdu_a2), .b2(mdu_b2), .divisor(mdu_dvs),
        .done(mdu_done), .ge(mdu_ge), .quot(mdu_q)
    );

    // Status to the controller.
    always_comb
    begin
        status.i_at_n   = (i_reg == cnt_reg);
        status.j_zero   = (j_reg == '0);
        status.last_out = (k_reg + CW'(1) == cnt_reg);
        status.mdu_done = mdu_done;
        status.mdu_ge   = mdu_ge;
    end

    assign bucket_index = out_idx_reg;
    assign share        = out_share_reg;
    assign dropped_flag = out_drop_reg;
    assign last_share   = out_last_reg;

endmodule

>>> hw/rtl/wfsa_ctrl.sv
// Controller: sequences loading, insertion sort, water filling and output.
// Depends on wfsa_pkg for the command and status types.
module wfsa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wfsa_pkg::dp_op_t     op,
    input  wfsa_pkg::dp_status_t status
);
    import wfsa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SORT_INIT,
        S_SORT_TOP,
        S_KEY_IDX,
        S_KEY_DAT,
        S_INNER,
        S_PREV_IDX,
        S_PREV_CMP,
        S_PREV_WAIT,
        S_PLACE,
        S_WALK_INIT,
        S_WALK_TOP,
        S_WALK_IDX,
        S_WALK_CMP,
        S_WALK_WAIT,
        S_FILL_TOP,
        S_FILL_IDX,
        S_FILL_DIV,
        S_FILL_WAIT,
        S_OUT_INIT,
        S_OUT_RD,
        S_OUT_LAT,
        S_OUT_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_fire;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    // Next state and datapath command.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        op             = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op = OP_LOAD;
                    if (in_last)
                    begin
                        state_next = S_SORT_INIT;
                    end
                end
            end
            S_SORT_INIT:
            begin
                op         = OP_SORT_INIT;
                state_next = S_SORT_TOP;
            end
            S_SORT_TOP:
            begin
                op         = OP_RD_ORD_I;
                state_next = status.i_at_n ? S_WALK_INIT : S_KEY_IDX;
            end
            S_KEY_IDX:
            begin
                op         = OP_LAT_KEY_IDX;
                state_next = S_KEY_DAT;
            end
            S_KEY_DAT:
            begin
                op         = OP_LAT_KEY_DAT;
                state_next = S_INNER;
            end
            S_INNER:
            begin
                op         = OP_RD_ORD_JM1;
                state_next = status.j_zero ? S_PLACE : S_PREV_IDX;
            end
            S_PREV_IDX:
            begin
                op         = OP_LAT_PREV_IDX;
                state_next = S_PREV_CMP;
            end
            S_PREV_CMP:
            begin
                op         = OP_CMP_SORT;
                state_next = S_PREV_WAIT;
            end
            S_PREV_WAIT:
            begin
                if (status.mdu_done)
                begin
                    if (status.mdu_ge)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        op         = OP_SHIFT;
                        state_next = S_INNER;
                    end
                end
            end
            S_PLACE:
            begin
                op         = OP_PLACE;
                state_next = S_SORT_TOP;
            end
            S_WALK_INIT:
            begin
                op         = OP_WALK_INIT;
                state_next = S_WALK_TOP;
            end
            S_WALK_TOP:
            begin
                op         = OP_RD_ORD_I;
                state_next = status.i_at_n ? S_OUT_INIT : S_WALK_IDX;
            end
            S_WALK_IDX:
            begin
                op         = OP_LAT_B_IDX;
                state_next = S_WALK_CMP;
            end
            S_WALK_CMP:
            begin
                op         = OP_CMP_WALK;
                state_next = S_WALK_WAIT;
            end
            S_WALK_WAIT:
            begin
                if (status.mdu_done)
                begin
                    if (status.mdu_ge)
                    begin
                        state_next = S_FILL_TOP;
                    end
                    else
                    begin
                        op         = OP_TAKE;
                        state_next = S_WALK_TOP;
                    end
                end
            end
            S_FILL_TOP:
            begin
                op         = OP_RD_ORD_I;
                state_next = status.i_at_n ? S_OUT_INIT : S_FILL_IDX;
            end
            S_FILL_IDX:
            begin
                op         = OP_LAT_B_IDX;
                state_next = S_FILL_DIV;
            end
            S_FILL_DIV:
            begin
                op         = OP_DIV;
                state_next = S_FILL_WAIT;
            end
            S_FILL_WAIT:
            begin
                if (status.mdu_done)
                begin
                    op         = OP_FILL_WR;
                    state_next = S_FILL_TOP;
                end
            end
            S_OUT_INIT:
            begin
                op         = OP_OUT_INIT;
                state_next = S_OUT_RD;
            end
            S_OUT_RD:
            begin
                op         = OP_RD_SHARE;
                state_next = S_OUT_LAT;
            end
            S_OUT_LAT:
            begin
                op             = OP_OUT_LAT;
                out_valid_next = 1'b1;
                state_next     = S_OUT_HOLD;
            end
            S_OUT_HOLD:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (status.last_out)
                    begin
                        op         = OP_CLEAR;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        op         = OP_NEXT_OUT;
                        state_next = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hw/rtl/weighted_fair_share_allocator_top.sv
// Weighted max-min fair share allocator (water filling), top level.
// Usage: bucket items arrive on in_ch, one transaction per bucket. Each carries
// a weight in hundredths, a demand and an optional bound; the transaction with
// last_bucket set also carries the capacity and starts the allocation.
// Buckets beyond MAX_BUCKETS are dropped and flagged on every result.
// in_ch stays ready while loading, so transactions can arrive back to back.
// After the last one the block sorts the buckets by capped demand over weight
// (insertion sort, one exact cross-product compare at a time), walks the sorted
// order granting full demands, and then divides the remaining capacity for the
// rest (one quotient bit per cycle in the shared divider). Results leave on
// out_ch in load order, one transaction per loaded bucket, each read from the
// share store, registered and held through any receiver stall; last_share
// marks the final one.
// in_ch is not ready from the last bucket until the final result is taken.
// The result register holds its payload while the receiver stalls.
// Reset clears the bucket count and the drop flag; the stores need no clearing.
// Depends on wfsa_pkg, wfsa_if, wfsa_ctrl and wfsa_dp.
module weighted_fair_share_allocator_top #(
    parameter int MAX_BUCKETS  = 16,
    parameter int AMOUNT_WIDTH = 48
) (
    input logic           clk,
    input logic           rst_n,
    wfsa_in_if.sink       in_ch,
    wfsa_out_if.source    out_ch
);
    import wfsa_pkg::*;

    dp_op_t     op;
    dp_status_t status;

    // Sequencer.
    wfsa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_last(in_ch.last_bucket), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .op(op), .status(status)
    );

    // Stores, arithmetic and result register.
    wfsa_dp #(.MAX_BUCKETS(MAX_BUCKETS), .AMOUNT_WIDTH(AMOUNT_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .op(op),
        .weight(in_ch.weight), .demand(in_ch.demand), .cap_amount(in_ch.cap_amount),
        .cap_valid(in_ch.cap_valid), .capacity(in_ch.capacity),
        .status(status),
        .bucket_index(out_ch.bucket_index), .share(out_ch.share),
        .dropped_flag(out_ch.dropped_flag), .last_share(out_ch.last_share)
    );

endmodule

>>> hw/rtl/wfsa_chk.sv
// Port-level checker for the allocator top level, with its bind statement.
// Depends on weighted_fair_share_allocator_top and wfsa_pkg.
module wfsa_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           in_last,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           out_last,
    input logic [wfsa_pkg::OUT_IDX_W-1:0] bucket_index
);

    // A stalled result keeps its valid and its index.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bucket_index))
        else $error("result changed while stalled");

    // No bucket is taken while results are being delivered.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready during result delivery");

    // The last bucket closes the input until the round is delivered.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("input still ready after last bucket");

    // The final result ends the round.
    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !out_valid && in_ready)
        else $error("round did not end after final result");

endmodule

bind weighted_fair_share_allocator_top wfsa_chk u_wfsa_chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .in_last(in_ch.last_bucket),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_last(out_ch.last_share),
    .bucket_index(out_ch.bucket_index)
);

>>> sim/weighted_fair_share_allocator_top_tb.sv
// Self-checking testbench for the weighted fair share allocator top level.
// Loads rounds of buckets, predicts each round's shares and checks every result.
// Depends on wfsa_pkg, wfsa_if and the allocator RTL.
module weighted_fair_share_allocator_top_tb;
    import wfsa_pkg::*;

    localparam int NBKT = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [OUT_IDX_W-1:0]   bucket_index;
        logic [FIELD_AMT_W-1:0] share;
        logic                   dropped_flag;
        logic                   last_share;
    } share_res_t;

    // Share predictor and the queue of shares still owed by the block.
    class share_board;
        logic [13:0]  wt [NBKT];
        logic [47:0]  cdem [NBKT];
        int           count;
        bit           overflow;
        share_res_t   pending [$];
        int           errors;
        int           checked;

        function void note_bucket(logic [13:0] w, logic [47:0] d, logic [47:0] c, logic cv,
                                  logic [47:0] capa, logic lst);
            int ord [NBKT];
            logic [47:0] grant [NBKT];
            int i, j, key;
            logic [127:0] remw, remc, q, r, dv;
            share_res_t e;
            if (w == 0)
                w = 1;
            if (count < NBKT)
            begin
                wt[count] = w;
                cdem[count] = (cv && c < d) ? c : d;
                count++;
            end
            else
                overflow = 1;
            if (!lst)
                return;
            // Stable insertion sort by capped demand over weight.
            for (i = 0; i < count; i++)
                ord[i] = i;
            for (i = 1; i < count; i++)
            begin
                key = ord[i];
                j = i;
                while (j > 0 && 128'(cdem[key]) * wt[ord[j-1]] < 128'(cdem[ord[j-1]]) * wt[key])
                begin
                    ord[j] = ord[j-1];
                    j--;
                end
                ord[j] = key;
            end
            remw = 0;
            remc = capa;
            for (i = 0; i < count; i++)
                remw += wt[i];
            // Grant full demands while the water level stays above them.
            for (i = 0; i < count; i++)
            begin
                if (128'(cdem[ord[i]]) * remw >= remc * wt[ord[i]])
                    break;
                grant[ord[i]] = cdem[ord[i]];
                remc -= cdem[ord[i]];
                remw -= wt[ord[i]];
            end
            dv = (remw > 0) ? remw : 1;
            q = remc / dv;
            r = remc % dv;
            for (; i < count; i++)
                grant[ord[i]] = 48'(wt[ord[i]] * q + (wt[ord[i]] * r) / dv);
            for (i = 0; i < count; i++)
            begin
                e.bucket_index = 4'(i);
                e.share = grant[i];
                e.dropped_flag = overflow;
                e.last_share = (i + 1 == count);
                pending.insert(pending.size(), e);
            end
            count = 0;
            overflow = 0;
        endfunction

        function void check_share(share_res_t got);
            share_res_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $error("unexpected share transaction, index %0d", got.bucket_index);
                errors++;
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (got.bucket_index !== e.bucket_index)
            begin
                $error("bucket_index: expected %0d, actual %0d", e.bucket_index, got.bucket_index);
                errors++;
            end
            if (got.share !== e.share)
            begin
                $error("share: expected %0d, actual %0d", e.share, got.share);
                errors++;
            end
            if (got.dropped_flag !== e.dropped_flag)
            begin
                $error("dropped_flag: expected %0b, actual %0b", e.dropped_flag, got.dropped_flag);
                errors++;
            end
            if (got.last_share !== e.last_share)
            begin
                $error("last_share: expected %0b, actual %0b", e.last_share, got.last_share);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    bit   quiet = 0;
    int   idle_cycles = 0;
    int   sent = 0;
    int   rounds = 0;
    share_board board = new();

    wfsa_in_if  in_ch();
    wfsa_out_if out_ch();

    weighted_fair_share_allocator_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    initial
    begin
        in_ch.valid = 0;
        in_ch.weight = 0;
        in_ch.demand = 0;
        in_ch.cap_amount = 0;
        in_ch.cap_valid = 0;
        in_ch.capacity = 0;
        in_ch.last_bucket = 0;
        out_ch.ready = 0;
    end

    // Receiver: random stalls except during the quiet stretch.
    always @(posedge clk)
    begin
        if (rst_n)
            out_ch.ready <= quiet || ($urandom_range(99) >= 17);
    end

    // A result seen with valid and ready mid-cycle is taken at the next edge.
    always @(negedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_share({out_ch.bucket_index, out_ch.share,
                               out_ch.dropped_flag, out_ch.last_share});
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(negedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("weighted_fair_share_allocator_top_tb: errors");
            $finish;
        end
    end

    function automatic logic [47:0] rand_amount(int mode);
        case (mode)
            0: return 48'($urandom_range(1000));
            1: return {16'($urandom), 32'($urandom)};
            2: return 48'hFFFF_FFFF_FFFF;
            default: return 48'($urandom_range(100000));
        endcase
    endfunction

    // Sends one bucket, with random gaps before it.
    task automatic send_bucket(logic [13:0] w, logic [47:0] d, logic [47:0] c, logic cv,
                               logic [47:0] capa, logic lst);
        while (!quiet && $urandom_range(99) < 17)
        begin
            in_ch.valid <= 0;
            @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.weight <= w;
        in_ch.demand <= d;
        in_ch.cap_amount <= c;
        in_ch.cap_valid <= cv;
        in_ch.capacity <= capa;
        in_ch.last_bucket <= lst;
        // Ready only moves at the rising edge, so look at it mid-cycle.
        @(negedge clk);
        while (!in_ch.ready)
            @(negedge clk);
        @(posedge clk);
        board.note_bucket(w, d, c, cv, capa, lst);
        sent++;
        if (lst)
            rounds++;
    endtask

    task automatic random_round(int n);
        int k;
        int mode;
        mode = $urandom_range(3);
        for (k = 0; k < n; k++)
            send_bucket(($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(1, 10000)),
                        rand_amount(mode), rand_amount($urandom_range(3)), 1'($urandom),
                        rand_amount(mode), k == n - 1);
    endtask

    initial
    begin
        int k;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, single bucket, ties, zero weight, zero capacity.
        send_bucket(14'd10000, 48'hFFFF_FFFF_FFFF, 48'd0, 1'b0, 48'hFFFF_FFFF_FFFF, 1'b1);
        send_bucket(14'd0, 48'd100, 48'd50, 1'b1, 48'd0, 1'b0);
        send_bucket(14'd1, 48'd100, 48'hFFFF_FFFF_FFFF, 1'b1, 48'd0, 1'b0);
        send_bucket(14'h3FFF, 48'd0, 48'd0, 1'b1, 48'd0, 1'b1);
        send_bucket(14'd100, 48'd40, 48'd0, 1'b0, 48'd0, 1'b0);
        send_bucket(14'd100, 48'd40, 48'd0, 1'b0, 48'd0, 1'b0);
        send_bucket(14'd200, 48'd500, 48'd30, 1'b1, 48'd0, 1'b0);
        send_bucket(14'd50, 48'd1000, 48'd0, 1'b0, 48'd150, 1'b1);
        // Overflow round: eighteen buckets, the last two dropped.
        for (k = 0; k < 18; k++)
            send_bucket(14'(k * 500 + 1), 48'(k * 37), 48'(k * 11), 1'(k), 48'd12345, k == 17);

        // Random rounds, with a stretch of no idling in the middle.
        while (sent < 100)
        begin
            quiet = (sent > 45 && sent < 75);
            random_round(($urandom_range(5) == 0) ? $urandom_range(16, 18) : $urandom_range(1, 6));
        end
        quiet = 0;
        in_ch.valid <= 0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Sent %0d buckets in %0d rounds; %0d shares checked.",
                 sent, rounds, board.checked);
        if (board.errors == 0)
            $display("weighted_fair_share_allocator_top_tb: clean");
        else
            $display("weighted_fair_share_allocator_top_tb: errors");
        $finish;
    end
endmodule
